/* hw/rtl/pftk_pkg.sv */
// ----------------------------------------------------------------------------
// pftk_pkg
// Shared types and constants for the prefix filter top-K count block.
// ----------------------------------------------------------------------------
package pftk_pkg;

    localparam int TOP_ENTRIES_DEF = 10;

    localparam int HITS_W   = 31;
    localparam int LINE_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int RPT_W    = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [HITS_W-1:0] HITS_MAX      = {HITS_W{1'b1}};
    localparam logic [HITS_W-1:0] THRESHOLD_RST = HITS_W'(500);
    localparam logic [RPT_W-1:0]  REPORTED_RST  = RPT_W'(10);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HITS_THRESHOLD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_REPORTED = 1'b1;

    // character codes
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_E     = 8'h65;
    localparam logic [BYTE_W-1:0] CH_N     = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        PF_E,
        PF_N,
        PF_SP,
        PF_OK,
        PF_SKIP
    } t_prefix;

    typedef enum logic [1:0] {
        TK_PRE_PAGE,
        TK_PAGE,
        TK_PRE_COUNT,
        TK_COUNT
    } t_token;

    typedef enum logic [1:0] {
        CS_LEAD,
        CS_BODY,
        CS_DONE
    } t_cstage;

    typedef enum logic {
        ST_PARSE,
        ST_REPORT
    } t_state;

    // line close event from the parser to the table
    typedef struct packed {
        logic              keep;
        logic [HITS_W-1:0] hits;
        logic [LINE_W-1:0] line;
    } t_line_evt;

    // report side control of the table
    typedef struct packed {
        logic pop;
        logic clear;
    } t_tbl_ctl;

endpackage

/* hw/rtl/pftk_parse.sv */
// ----------------------------------------------------------------------------
// pftk_parse
// Byte parser: prefix match, token skip, atoi-style count, line numbering.
// ----------------------------------------------------------------------------
module pftk_parse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [pftk_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                          i_end_of_stream,
    input  logic [pftk_pkg::HITS_W-1:0]   i_threshold,
    output pftk_pkg::t_line_evt           o_evt
);
    import pftk_pkg::*;

    t_prefix           r_pre, p_pre;
    t_token            r_tok, p_tok;
    t_cstage           r_cs, p_cs;
    logic [HITS_W-1:0] r_acc, p_acc;
    logic              r_neg, p_neg;
    logic [LINE_W-1:0] r_line, n_line;

    logic              w_cnt_byte;
    logic              w_digit;
    logic              w_ws;
    logic              w_close;
    logic [HITS_W+3:0] w_mac;
    logic [HITS_W-1:0] w_acc_sat;

    assign w_digit = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
    assign w_ws    = (i_data_byte >= CH_TAB) && (i_data_byte <= CH_CR);

    // acc * 10 + digit, saturating
    assign w_mac = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                 + {{(HITS_W){1'b0}}, i_data_byte[3:0]};
    assign w_acc_sat = (w_mac > {4'b0, HITS_MAX}) ? HITS_MAX : w_mac[HITS_W-1:0];

    always_comb begin
        p_pre      = r_pre;
        p_tok      = r_tok;
        p_cs       = r_cs;
        p_acc      = r_acc;
        p_neg      = r_neg;
        w_cnt_byte = 1'b0;
        if (i_data_byte != CH_LF) begin
            case (r_pre)
                PF_E:  p_pre = (i_data_byte == CH_E)  ? PF_N  : PF_SKIP;
                PF_N:  p_pre = (i_data_byte == CH_N)  ? PF_SP : PF_SKIP;
                PF_SP: p_pre = (i_data_byte == CH_SP) ? PF_OK : PF_SKIP;
                PF_OK: begin
                    case (r_tok)
                        TK_PRE_PAGE: begin
                            if (i_data_byte != CH_SP) p_tok = TK_PAGE;
                        end
                        TK_PAGE: begin
                            if (i_data_byte == CH_SP) p_tok = TK_PRE_COUNT;
                        end
                        TK_PRE_COUNT: begin
                            if (i_data_byte != CH_SP) begin
                                p_tok      = TK_COUNT;
                                w_cnt_byte = 1'b1;
                            end
                        end
                        default: begin
                            if (i_data_byte == CH_SP) begin
                                p_cs = CS_DONE;
                            end else begin
                                w_cnt_byte = 1'b1;
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end
        if (w_cnt_byte) begin
            case (r_cs)
                CS_LEAD: begin
                    if (!w_ws) begin
                        p_cs = CS_BODY;
                        if (i_data_byte == CH_MINUS) begin
                            p_neg = 1'b1;
                        end else if (i_data_byte == CH_PLUS) begin
                            p_neg = r_neg;
                        end else if (!w_digit) begin
                            p_cs = CS_DONE;
                        end else begin
                            p_acc = w_acc_sat;
                        end
                    end
                end
                CS_BODY: begin
                    if (w_digit) begin
                        p_acc = w_acc_sat;
                    end else begin
                        p_cs = CS_DONE;
                    end
                end
                default: p_cs = CS_DONE;
            endcase
        end
    end

    assign w_close = (i_data_byte == CH_LF) || i_end_of_stream;
    assign n_line  = i_end_of_stream ? '0 : r_line + LINE_W'(1);

    always_comb begin
        o_evt.keep = i_accept && w_close && (p_pre == PF_OK) && (p_tok == TK_COUNT)
                   && !p_neg && (p_acc > i_threshold);
        o_evt.hits = p_acc;
        o_evt.line = r_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre  <= PF_E;
            r_tok  <= TK_PRE_PAGE;
            r_cs   <= CS_LEAD;
            r_acc  <= '0;
            r_neg  <= 1'b0;
            r_line <= '0;
        end else if (i_accept) begin
            if (w_close) begin
                r_pre  <= PF_E;
                r_tok  <= TK_PRE_PAGE;
                r_cs   <= CS_LEAD;
                r_acc  <= '0;
                r_neg  <= 1'b0;
                r_line <= n_line;
            end else begin
                r_pre <= p_pre;
                r_tok <= p_tok;
                r_cs  <= p_cs;
                r_acc <= p_acc;
                r_neg <= p_neg;
            end
        end
    end

endmodule

/* hw/rtl/pftk_table.sv */
// ----------------------------------------------------------------------------
// pftk_table
// Sorted top-K register table: parallel insert, shift-up pop for readout.
// ----------------------------------------------------------------------------
module pftk_table #(
    parameter int TOP_ENTRIES = pftk_pkg::TOP_ENTRIES_DEF,
    parameter int FILL_W      = $clog2(TOP_ENTRIES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pftk_pkg::t_line_evt           i_evt,
    input  pftk_pkg::t_tbl_ctl            i_ctl,
    output logic [pftk_pkg::HITS_W-1:0]   o_head_hits,
    output logic [pftk_pkg::LINE_W-1:0]   o_head_line,
    output logic [FILL_W-1:0]             o_fill
);
    import pftk_pkg::*;

    logic [HITS_W-1:0] r_hits [TOP_ENTRIES];
    logic [LINE_W-1:0] r_lines [TOP_ENTRIES];
    logic [HITS_W-1:0] n_hits [TOP_ENTRIES];
    logic [LINE_W-1:0] n_lines [TOP_ENTRIES];
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [TOP_ENTRIES-1:0] w_ge;

    // entries at or above the new count; a prefix since the table is sorted
    always_comb begin
        for (int i = 0; i < TOP_ENTRIES; i++) begin
            w_ge[i] = (FILL_W'(i) < r_fill) && (r_hits[i] >= i_evt.hits);
        end
    end

    always_comb begin
        n_fill = r_fill;
        for (int i = 0; i < TOP_ENTRIES; i++) begin
            n_hits[i]  = r_hits[i];
            n_lines[i] = r_lines[i];
        end
        if (i_ctl.clear) begin
            n_fill = '0;
        end else if (i_evt.keep && !w_ge[TOP_ENTRIES-1]) begin
            for (int i = 0; i < TOP_ENTRIES; i++) begin
                if (!w_ge[i]) begin
                    if (i == 0) begin
                        n_hits[i]  = i_evt.hits;
                        n_lines[i] = i_evt.line;
                    end else if (w_ge[i-1]) begin
                        n_hits[i]  = i_evt.hits;
                        n_lines[i] = i_evt.line;
                    end else begin
                        n_hits[i]  = r_hits[i-1];
                        n_lines[i] = r_lines[i-1];
                    end
                end
            end
            if (r_fill < FILL_W'(TOP_ENTRIES)) n_fill = r_fill + FILL_W'(1);
        end
        if (i_ctl.pop) begin
            for (int i = 0; i < TOP_ENTRIES - 1; i++) begin
                n_hits[i]  = r_hits[i+1];
                n_lines[i] = r_lines[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TOP_ENTRIES; i++) begin
            r_hits[i]  <= n_hits[i];
            r_lines[i] <= n_lines[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_head_hits = r_hits[0];
    assign o_head_line = r_lines[0];
    assign o_fill      = r_fill;

endmodule

/* hw/rtl/prefix_filter_top_k_counts.sv */
// ----------------------------------------------------------------------------
// prefix_filter_top_k_counts
// Log line filter: parses "en " lines, keeps the top-K counts, reports at EOS.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle unless stalled; insert at the beat edge.
// Start: EOS beat enters report state, then first result beat is registered.
// Report: one result beat per cycle from table head, unless output is stalled;
//   input stalls for the report; max(1, min(entries_reported, fill)) beats.
// Reset: synchronous active low; parser, line number, fill, state, config reset.
// ----------------------------------------------------------------------------
module prefix_filter_top_k_counts #(
    parameter int TOP_ENTRIES = pftk_pkg::TOP_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [pftk_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                              i_end_of_stream,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [pftk_pkg::HITS_W-1:0]       o_entry_hits,
    output logic [pftk_pkg::LINE_W-1:0]       o_entry_line,
    output logic                              o_entry_valid,
    output logic                              o_last_entry,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pftk_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pftk_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import pftk_pkg::*;

    localparam int FILL_W = $clog2(TOP_ENTRIES + 1);
    localparam int CW     = FILL_W + RPT_W;

    logic [HITS_W-1:0] r_threshold;
    logic [RPT_W-1:0]  r_reported;
    t_state            r_state, n_state;
    logic [FILL_W-1:0] r_rep_cnt;
    logic              r_out_valid;
    logic [HITS_W-1:0] r_entry_hits;
    logic [LINE_W-1:0] r_entry_line;
    logic              r_entry_valid;
    logic              r_last_entry;

    logic              w_in_accept;
    t_line_evt         w_evt;
    t_tbl_ctl          w_ctl;
    logic [HITS_W-1:0] w_head_hits;
    logic [LINE_W-1:0] w_head_line;
    logic [FILL_W-1:0] w_fill;
    logic [CW-1:0]     w_req, w_cap, w_n_wide;
    logic [FILL_W-1:0] w_n;
    logic              w_last;
    logic              w_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_reported  <= REPORTED_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HITS_THRESHOLD:   r_threshold <= i_cfg_data[HITS_W-1:0];
                CFG_ENTRIES_REPORTED: r_reported  <= i_cfg_data[RPT_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_in_accept = i_in_valid && !o_in_stall;

    pftk_parse u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_in_accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_threshold     (r_threshold),
        .o_evt           (w_evt)
    );

    pftk_table #(
        .TOP_ENTRIES (TOP_ENTRIES),
        .FILL_W      (FILL_W)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (w_evt),
        .i_ctl       (w_ctl),
        .o_head_hits (w_head_hits),
        .o_head_line (w_head_line),
        .o_fill      (w_fill)
    );

    // entries to report: register value clamped to 1..TOP, then to fill
    always_comb begin
        w_req    = (r_reported == '0) ? CW'(1) : CW'(r_reported);
        w_cap    = (w_req > CW'(TOP_ENTRIES)) ? CW'(TOP_ENTRIES) : w_req;
        w_n_wide = (w_cap > CW'(w_fill)) ? CW'(w_fill) : w_cap;
    end
    assign w_n    = w_n_wide[FILL_W-1:0];
    assign w_last = (w_n == '0) || ((r_rep_cnt + FILL_W'(1)) == w_n);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_PARSE:  if (w_in_accept && i_end_of_stream) n_state = ST_REPORT;
            ST_REPORT: if (w_load && w_last) n_state = ST_PARSE;
            default:   n_state = ST_PARSE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b0;
        w_load     = 1'b0;
        w_ctl      = '0;
        case (r_state)
            ST_REPORT: begin
                o_in_stall = 1'b1;
                w_load     = !r_out_valid || !i_out_stall;
                w_ctl.pop  = w_load && (w_n != '0);
                w_ctl.clear = w_load && w_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_PARSE;
            r_rep_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_rep_cnt <= w_last ? '0 : r_rep_cnt + FILL_W'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_entry_valid <= (w_n != '0);
            r_entry_hits  <= (w_n != '0) ? w_head_hits : '0;
            r_entry_line  <= (w_n != '0) ? w_head_line : '0;
            r_last_entry  <= w_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_hits  = r_entry_hits;
    assign o_entry_line  = r_entry_line;
    assign o_entry_valid = r_entry_valid;
    assign o_last_entry  = r_last_entry;

    a_eos_enters_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && i_end_of_stream) |=> (r_state == ST_REPORT))
        else $error("end-of-stream beat did not start a report");

    a_last_ends_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> ((r_state == ST_PARSE) && (w_fill == '0)))
        else $error("report did not close with an empty table");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fill <= FILL_W'(TOP_ENTRIES)))
        else $error("table fill exceeds capacity");

    a_rep_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPORT) |-> ((r_rep_cnt < w_n) || (w_n == '0)))
        else $error("report index past the reported count");

endmodule
